@@ rtl/core/rde_pkg.sv @@
`timescale 1ns / 1ps

package rde_pkg;

   localparam int KindWidth    = 3;
   localparam int DataWidth    = 16;
   localparam int StatusWidth  = 2;

   // input kinds
   localparam logic [KindWidth-1:0] KIND_CLEAR   = 3'd0;
   localparam logic [KindWidth-1:0] KIND_PUSH    = 3'd1;
   localparam logic [KindWidth-1:0] KIND_REVERSE = 3'd2;
   localparam logic [KindWidth-1:0] KIND_DELETE  = 3'd3;
   localparam logic [KindWidth-1:0] KIND_READ    = 3'd4;

   // internal operations
   localparam logic [2:0] OP_CLEAR   = 3'd0;
   localparam logic [2:0] OP_PUSH    = 3'd1;
   localparam logic [2:0] OP_REVERSE = 3'd2;
   localparam logic [2:0] OP_DELETE  = 3'd3;
   localparam logic [2:0] OP_READ    = 3'd4;

   // result status
   localparam logic [StatusWidth-1:0] ST_ELEMENT  = 2'd0;
   localparam logic [StatusWidth-1:0] ST_EMPTY    = 2'd1;
   localparam logic [StatusWidth-1:0] ST_ERROR    = 2'd2;
   localparam logic [StatusWidth-1:0] ST_OVERFLOW = 2'd3;

   typedef struct packed {
      logic [2:0]           op;
      logic [DataWidth-1:0] value;
   } op_type;

   typedef struct packed {
      logic [DataWidth-1:0]   element;
      logic [StatusWidth-1:0] status;
      logic                   last;
   } rsp_type;

endpackage

@@ rtl/core/rde_front.sv @@
`timescale 1ns / 1ps

module rde_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [rde_pkg::KindWidth-1:0] req_kind,
   input  logic [rde_pkg::DataWidth-1:0] req_value,
   output logic                          op_valid,
   input  logic                          op_ready,
   output rde_pkg::op_type               op
);
   import rde_pkg::*;

   op_type     q_ff [2];
   op_type     q_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       known;
   logic       push;
   logic       pop;

   always_comb begin
      known   = 1'b1;
      q_in.op = OP_CLEAR;
      q_in.value = req_value;
      unique case (req_kind)
         KIND_CLEAR:   q_in.op = OP_CLEAR;
         KIND_PUSH:    q_in.op = OP_PUSH;
         KIND_REVERSE: q_in.op = OP_REVERSE;
         KIND_DELETE:  q_in.op = OP_DELETE;
         KIND_READ:    q_in.op = OP_READ;
         default:      known = 1'b0;
      endcase
   end

   assign req_tready = (cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready && known;
   assign op_valid   = (cnt_ff != 2'd0);
   assign op         = q_ff[rd_ptr_ff];
   assign pop        = op_valid && op_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
   end

endmodule

@@ rtl/core/rde_back.sv @@
`timescale 1ns / 1ps

module rde_back #(
   parameter int DEPTH       = 64,
   parameter int VALUE_WIDTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             op_valid,
   output logic             op_ready,
   input  rde_pkg::op_type  op,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rde_pkg::rsp_type rsp
);
   import rde_pkg::*;

   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = (VALUE_WIDTH < DataWidth) ? VALUE_WIDTH : DataWidth;

   localparam logic S_IDLE   = 1'b0;
   localparam logic S_STREAM = 1'b1;

   logic [SW-1:0] mem [DEPTH];
   logic [SW-1:0] rd_data_ff;

   logic          state_ff, state_in;
   logic [IW-1:0] head_ff, head_in;
   logic [CW-1:0] count_ff, count_in;
   logic          rev_ff, rev_in;
   logic          err_ff, err_in;
   logic [IW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] remain_ff, remain_in;

   logic                   pend_ff, pend_in;
   logic [StatusWidth-1:0] pend_st_ff, pend_st_in;
   logic                   pend_last_ff, pend_last_in;

   rsp_type    rq_ff [4];
   rsp_type    rq_entry;
   logic [1:0] rq_wr_ff, rq_rd_ff;
   logic [2:0] occ_ff, occ_in;
   logic       rq_pop;

   logic          space;
   logic          full;
   logic          we;
   logic          rd_en;
   logic [CW:0]   tail_sum;
   logic [CW:0]   last_sum;
   logic [IW-1:0] tail_addr;
   logic [IW-1:0] last_addr;
   logic [IW-1:0] ptr_inc;
   logic [IW-1:0] ptr_dec;
   logic [IW-1:0] head_inc;

   assign full  = (count_ff == CW'(DEPTH));
   assign space = (occ_ff + 3'(pend_ff)) <= 3'd2;

   always_comb begin
      tail_sum  = (CW+1)'(head_ff) + (CW+1)'(count_ff);
      last_sum  = tail_sum - (CW+1)'(1);
      tail_addr = (tail_sum >= (CW+1)'(DEPTH)) ? IW'(tail_sum - (CW+1)'(DEPTH))
                                               : IW'(tail_sum);
      last_addr = (last_sum >= (CW+1)'(DEPTH)) ? IW'(last_sum - (CW+1)'(DEPTH))
                                               : IW'(last_sum);
      ptr_inc   = (ptr_ff == IW'(DEPTH - 1)) ? '0 : ptr_ff + IW'(1);
      ptr_dec   = (ptr_ff == '0) ? IW'(DEPTH - 1) : ptr_ff - IW'(1);
      head_inc  = (head_ff == IW'(DEPTH - 1)) ? '0 : head_ff + IW'(1);
   end

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      rev_in       = rev_ff;
      err_in       = err_ff;
      ptr_in       = ptr_ff;
      remain_in    = remain_ff;
      pend_in      = 1'b0;
      pend_st_in   = ST_ELEMENT;
      pend_last_in = 1'b0;
      op_ready     = 1'b0;
      we           = 1'b0;
      rd_en        = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (op_valid && space) begin
               op_ready = 1'b1;
               unique case (op.op)
                  OP_CLEAR: begin
                     head_in  = '0;
                     count_in = '0;
                     rev_in   = 1'b0;
                     err_in   = 1'b0;
                  end
                  OP_PUSH: begin
                     if (full) begin
                        pend_in      = 1'b1;
                        pend_st_in   = ST_OVERFLOW;
                        pend_last_in = 1'b1;
                     end else begin
                        we       = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  OP_REVERSE: rev_in = ~rev_ff;
                  OP_DELETE: begin
                     if (count_ff == '0) begin
                        err_in = 1'b1;
                     end else begin
                        count_in = count_ff - CW'(1);
                        if (!rev_ff) begin
                           head_in = head_inc;
                        end
                     end
                  end
                  OP_READ: begin
                     if (err_ff) begin
                        pend_in      = 1'b1;
                        pend_st_in   = ST_ERROR;
                        pend_last_in = 1'b1;
                     end else if (count_ff == '0) begin
                        pend_in      = 1'b1;
                        pend_st_in   = ST_EMPTY;
                        pend_last_in = 1'b1;
                     end else begin
                        state_in  = S_STREAM;
                        remain_in = count_ff;
                        ptr_in    = rev_ff ? last_addr : head_ff;
                     end
                  end
                  default: ;
               endcase
            end
         end
         S_STREAM: begin
            if (space) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_st_in   = ST_ELEMENT;
               pend_last_in = (remain_ff == CW'(1));
               remain_in    = remain_ff - CW'(1);
               ptr_in       = rev_ff ? ptr_dec : ptr_inc;
               if (remain_ff == CW'(1)) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff  <= '0;
         count_ff <= '0;
         rev_ff   <= 1'b0;
         err_ff   <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         count_ff <= count_in;
         rev_ff   <= rev_in;
         err_ff   <= err_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      remain_ff    <= remain_in;
      pend_st_ff   <= pend_st_in;
      pend_last_ff <= pend_last_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[tail_addr] <= op.value[SW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[ptr_ff];
      end
   end

   // result queue, four deep
   always_comb begin
      rq_entry.element = (pend_st_ff == ST_ELEMENT) ? DataWidth'(rd_data_ff) : '0;
      rq_entry.status  = pend_st_ff;
      rq_entry.last    = pend_last_ff;
   end

   assign rsp_valid = (occ_ff != 3'd0);
   assign rsp       = rq_ff[rq_rd_ff];
   assign rq_pop    = rsp_valid && rsp_ready;
   assign occ_in    = occ_ff + 3'(pend_ff) - 3'(rq_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff <= 2'd0;
         rq_rd_ff <= 2'd0;
         occ_ff   <= 3'd0;
      end else begin
         rq_wr_ff <= rq_wr_ff + 2'(pend_ff);
         rq_rd_ff <= rq_rd_ff + 2'(rq_pop);
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff) begin
         rq_ff[rq_wr_ff] <= rq_entry;
      end
   end

endmodule

@@ rtl/core/reversible_deque_engine.sv @@
`timescale 1ns / 1ps
// Reversible deque engine: a list of up to DEPTH values with lazy reverse.
// Request channel (req_): tuser carries the kind (clear, push, reverse,
// delete front, read out), tdata the value to push. Kinds 5 to 7 are dropped.
// Response channel (rsp_): tdata is the element, tuser the status (element,
// empty, error, overflow), tlast marks the final result of one read out.
// A two-entry command queue takes one transaction per cycle while it is not
// full; the execution side takes a new clear, push, reverse or delete
// whenever it is idle and the response queue has room. A read out of n
// elements streams n results, one per cycle while the response queue has
// room, limited by the single read port of the element store.
// Reset (synchronous) empties the list and clears the reverse and error
// flags; it needs no clearing pass, since the store is only read at
// entries that were written.
// When rsp_tready is low the four-entry response queue fills, streaming
// pauses, then the command queue fills and req_tready drops.
module reversible_deque_engine #(
   parameter int DEPTH       = 64,
   parameter int VALUE_WIDTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] value
   input  logic [2:0]  req_tuser,   // [2:0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] element
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast
);
   import rde_pkg::*;

   logic    op_valid;
   logic    op_ready;
   op_type  op;
   rsp_type rsp;

   rde_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .req_value  (req_tdata),
      .op_valid   (op_valid),
      .op_ready   (op_ready),
      .op         (op)
   );

   rde_back #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_valid  (op_valid),
      .op_ready  (op_ready),
      .op        (op),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = rsp.element;
   assign rsp_tuser = rsp.status;
   assign rsp_tlast = rsp.last;

endmodule

@@ rtl/core/rde_checker.sv @@
`timescale 1ns / 1ps

module rde_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import rde_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   a_status_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_ELEMENT) |-> rsp_tlast)
      else $error("status result not marked last");

   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != ST_ELEMENT) |-> (rsp_tdata == 16'd0))
      else $error("status result carries nonzero element");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("request not ready right after reset");

endmodule

bind reversible_deque_engine rde_checker u_rde_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

@@ test/reversible_deque_engine_tb.sv @@
`timescale 1ns / 1ps

module reversible_deque_engine_tb;
   import rde_pkg::*;

   localparam int LIST_DEPTH  = 64;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int DRAIN_WAIT  = 20;
   localparam int DUE_DEPTH   = 1024;

   localparam logic [KindWidth-1:0] KIND_FIRST_UNUSED = 3'd5;
   localparam logic [KindWidth-1:0] KIND_SPARE_UNUSED = 3'd6;
   localparam logic [KindWidth-1:0] KIND_LAST_UNUSED  = 3'd7;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [DataWidth-1:0]   req_tdata = '0;
   logic [KindWidth-1:0]   req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [DataWidth-1:0]   rsp_tdata;
   logic [StatusWidth-1:0] rsp_tuser;
   logic                   rsp_tlast;

   // list state as the engine should hold it
   logic [DataWidth-1:0] model_store [LIST_DEPTH];
   logic [5:0]           model_head;
   logic [6:0]           model_count;
   logic                 model_reversed;
   logic                 model_error;

   // expected results, in order
   rsp_type due_ring [DUE_DEPTH];
   int      due_wr = 0;
   int      due_rd = 0;

   int mismatch_count = 0;
   int cycle_count    = 0;
   int burst_left     = 0;
   int gap_max        = 0;
   int stall_pct      = 0;
   int hold_request   = 0;

   reversible_deque_engine #(
      .DEPTH       (LIST_DEPTH),
      .VALUE_WIDTH (DataWidth)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("reversible_deque_engine regression: fail");
         $finish;
      end
   end

   function automatic logic [DataWidth-1:0] rand_value();
      return DataWidth'($urandom);
   endfunction

   function automatic void queue_output(input logic [DataWidth-1:0] element,
                                        input logic [StatusWidth-1:0] status,
                                        input logic last);
      rsp_type r;
      r.element = element;
      r.status  = status;
      r.last    = last;
      due_ring[10'(due_wr)] = r;
      due_wr++;
   endfunction

   function automatic void predict_list_op(input logic [KindWidth-1:0] kind,
                                           input logic [DataWidth-1:0] value);
      int unsigned off;
      case (kind)
         KIND_CLEAR: begin
            model_head     = '0;
            model_count    = '0;
            model_reversed = 1'b0;
            model_error    = 1'b0;
         end
         KIND_PUSH: begin
            if (model_count >= LIST_DEPTH) begin
               queue_output('0, ST_OVERFLOW, 1'b1);
            end else begin
               model_store[6'((model_head + model_count) % LIST_DEPTH)] = value;
               model_count = model_count + 1'b1;
            end
         end
         KIND_REVERSE: model_reversed = !model_reversed;
         KIND_DELETE: begin
            if (model_count == 0) begin
               model_error = 1'b1;
            end else begin
               if (!model_reversed) model_head = model_head + 1'b1;
               model_count = model_count - 1'b1;
            end
         end
         KIND_READ: begin
            if (model_error) begin
               queue_output('0, ST_ERROR, 1'b1);
            end else if (model_count == 0) begin
               queue_output('0, ST_EMPTY, 1'b1);
            end else begin
               for (int k = 0; k < model_count; k++) begin
                  off = model_reversed ? (model_count - 1 - k) : k;
                  queue_output(model_store[6'((model_head + off) % LIST_DEPTH)], ST_ELEMENT,
                               k + 1 == model_count);
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_request(input logic [KindWidth-1:0] kind,
                               input logic [DataWidth-1:0] value);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_list_op(kind, value);
      if (burst_left > 0) begin
         burst_left--;
      end else if (gap_max > 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(gap_max, 1)) @(posedge clock);
         burst_left = $urandom_range(12);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (due_wr != due_rd) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // receiver: random stalls at a set rate, plus counted hold-offs on request
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   always @(posedge clock) begin : check_outputs
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_wr == due_rd) begin
            $display("%0t: unexpected transaction: element %h status %0d last %0b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            want = due_ring[10'(due_rd)];
            due_rd++;
            if (rsp_tdata !== want.element) begin
               $display("%0t: element expected %h actual %h", $time, want.element, rsp_tdata);
               mismatch_count++;
            end
            if (rsp_tuser !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last expected %0b actual %0b", $time, want.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   task automatic test_directed_ops();
      gap_max   = 0;
      stall_pct = 0;
      send_request(KIND_READ, 16'hFFFF);
      send_request(KIND_PUSH, 16'h0000);
      send_request(KIND_PUSH, 16'hFFFF);
      send_request(KIND_PUSH, 16'h8001);
      send_request(KIND_READ, 16'h0000);
      send_request(KIND_REVERSE, 16'hFFFF);
      send_request(KIND_READ, 16'h0000);
      send_request(KIND_DELETE, 16'hFFFF);
      send_request(KIND_READ, 16'h0000);
      send_request(KIND_REVERSE, 16'h0000);
      send_request(KIND_DELETE, 16'h0000);
      send_request(KIND_READ, 16'h0000);
      send_request(KIND_DELETE, 16'h0000);
      send_request(KIND_DELETE, 16'h0000);
      send_request(KIND_READ, 16'h0000);
      send_request(KIND_PUSH, 16'h1234);
      send_request(KIND_REVERSE, 16'h0000);
      send_request(KIND_READ, 16'h0000);
      send_request(KIND_CLEAR, 16'hFFFF);
      send_request(KIND_READ, 16'h0000);
      send_request(KIND_FIRST_UNUSED, 16'hFFFF);
      send_request(KIND_SPARE_UNUSED, 16'h5555);
      send_request(KIND_LAST_UNUSED, 16'hAAAA);
      send_request(KIND_READ, 16'h0000);
   endtask

   task automatic test_full_store();
      gap_max   = 3;
      stall_pct = 30;
      send_request(KIND_CLEAR, rand_value());
      repeat (LIST_DEPTH) send_request(KIND_PUSH, rand_value());
      send_request(KIND_PUSH, 16'hFFFF);
      send_request(KIND_PUSH, rand_value());
      send_request(KIND_READ, rand_value());
      repeat (5) send_request(KIND_DELETE, rand_value());
      repeat (5) send_request(KIND_PUSH, rand_value());
      send_request(KIND_PUSH, rand_value());
      send_request(KIND_REVERSE, rand_value());
      send_request(KIND_READ, rand_value());
      repeat (10) send_request(KIND_DELETE, rand_value());
      send_request(KIND_READ, rand_value());
      send_request(KIND_REVERSE, rand_value());
      send_request(KIND_READ, rand_value());
   endtask

   task automatic test_backpressure();
      gap_max   = 0;
      stall_pct = 0;
      send_request(KIND_CLEAR, rand_value());
      hold_request = 300;
      repeat (24) send_request(KIND_PUSH, rand_value());
      repeat (6) begin
         send_request(KIND_READ, rand_value());
         send_request(KIND_REVERSE, rand_value());
         send_request(KIND_PUSH, rand_value());
      end
   endtask

   task automatic test_random_ops();
      int pick;
      logic [KindWidth-1:0] kind;
      bit growing;
      for (int chunk = 0; chunk < 6; chunk++) begin
         growing = (chunk % 3 != 2);
         case ($urandom_range(2))
            0: gap_max = 0;
            1: gap_max = 3;
            default: gap_max = 8;
         endcase
         case ($urandom_range(3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 90;
         endcase
         repeat (28) begin
            pick = $urandom_range(99);
            if (pick < (growing ? 55 : 25))      kind = KIND_PUSH;
            else if (pick < (growing ? 65 : 40)) kind = KIND_READ;
            else if (pick < (growing ? 75 : 50)) kind = KIND_REVERSE;
            else if (pick < 92)                  kind = KIND_DELETE;
            else if (pick < 95)                  kind = KIND_CLEAR;
            else kind = KindWidth'($urandom_range(KIND_LAST_UNUSED, KIND_FIRST_UNUSED));
            send_request(kind, rand_value());
         end
      end
      send_request(KIND_READ, rand_value());
   endtask

   initial begin
      model_head     = '0;
      model_count    = '0;
      model_reversed = 1'b0;
      model_error    = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_ops();
      test_full_store();
      test_backpressure();
      test_random_ops();
      wait_drained();

      if (mismatch_count == 0) begin
         $display("reversible_deque_engine regression: pass");
      end else begin
         $display("reversible_deque_engine regression: fail");
      end
      $finish;
   end

endmodule

@@ reversible_deque_engine.f @@
rtl/core/rde_pkg.sv
rtl/core/rde_front.sv
rtl/core/rde_back.sv
rtl/core/reversible_deque_engine.sv
rtl/core/rde_checker.sv
test/reversible_deque_engine_tb.sv
